// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LHC_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("lhc: assertion failed");
`define LHC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("lhc: implication failed");
`else
`define LHC_ASSERT(lbl, clk, rstn, prop)
`define LHC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/lhc_pkg.sv =====
// Types and constants of the LRU handle cache.
package lhc_pkg;
	localparam int CAPACITY_DEF = 256;
	localparam int KEY_BITS_DEF = 64;
	localparam int KEY_W = 64;
	localparam int LIMIT_W = 9;
	localparam int SLOT_W = 8;
	localparam int EVC_W = 8;
	localparam int FILL_W = 2;
	localparam int LIMIT_FLOOR = 16;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd192;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_PEEK = 1'b1;

	localparam logic [FILL_W-1:0] FILL_DECODE_FAIL = 2'd0;
	localparam logic [FILL_W-1:0] FILL_UPLOAD_FAIL = 2'd1;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_CMP,
		CELL_TOUCH,
		CELL_EVICT,
		CELL_INSERT
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_DECIDE,
		ST_TOUCH,
		ST_EVICT,
		ST_INSERT,
		ST_DONE
	} state_t;
endpackage

// ===== design/lhc_cell.sv =====
// One cache entry: key, valid bit, age rank and match flag.
module lhc_cell #(
	parameter int KEY_BITS = lhc_pkg::KEY_BITS_DEF,
	parameter int RANK_W = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lhc_pkg::cell_op_t     cmd,
	input  logic [KEY_BITS-1:0]   key_in,
	input  logic [RANK_W-1:0]     ref_rank,
	input  logic [RANK_W-1:0]     new_rank,
	input  logic                  free_in,
	output logic                  free_out,
	output logic                  sel,
	output logic                  valid,
	output logic                  match,
	output logic [RANK_W-1:0]     rank
);
	import lhc_pkg::*;

	logic                valid_q;
	logic                match_q;
	logic [KEY_BITS-1:0] key_q;
	logic [RANK_W-1:0]   rank_q;

	// lowest free entry: first invalid cell along the chain
	assign sel      = !valid_q && !free_in;
	assign free_out = free_in || !valid_q;
	assign valid    = valid_q;
	assign match    = match_q;
	assign rank     = rank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			case (cmd)
				CELL_CMP: begin
					match_q <= valid_q && (key_q == key_in);
				end
				CELL_EVICT: begin
					if (valid_q && rank_q == '0) begin
						valid_q <= 1'b0;
					end
				end
				CELL_INSERT: begin
					if (sel) begin
						valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CELL_TOUCH: begin
				if (match_q) begin
					rank_q <= new_rank;
				end else if (valid_q && rank_q > ref_rank) begin
					rank_q <= rank_q - 1'b1;
				end
			end
			CELL_EVICT: begin
				if (valid_q && rank_q != '0) begin
					rank_q <= rank_q - 1'b1;
				end
			end
			CELL_INSERT: begin
				if (sel) begin
					key_q  <= key_in;
					rank_q <= new_rank;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

// ===== design/lru_handle_cache_policy_top.sv =====
// Top level of the LRU handle cache: control, cell row and result register.
// Usage:
//   Input channel (in_valid/in_ready) carries op, key and fill_outcome. Output
//   channel (out_valid/out_ready) returns one beat per item: hit, handle_valid,
//   slot and evicted_count. The cfg channel (cfg_valid/cfg_ready, cfg_data)
//   writes live_limit and is always ready; write it only while idle.
//   All entries sit in a row of cells that compare the key in parallel; the
//   lowest free entry is found by a free chain running through the row.
//   Each item runs from accept through the compare and decide states to the
//   result register; a peek or a miss with failed decode goes straight on,
//   a lookup hit passes the touch state and any other miss the evict state,
//   evicting one entry per cycle, then the insert state if the fill succeeded.
//   The next item is accepted in the cycle after the result is loaded.
//   Reset clears all valid bits and the live count at once and sets
//   live_limit to 192. If the receiver stalls, the result waits in the
//   output register; one further item may be accepted and worked on, and
//   it holds before loading until the register is free.
`include "assert_macros.svh"
module lru_handle_cache_policy_top #(
	parameter int CAPACITY = lhc_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = lhc_pkg::KEY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [lhc_pkg::KEY_W-1:0]     key,
	input  logic [lhc_pkg::FILL_W-1:0]    fill_outcome,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic                          handle_valid,
	output logic [lhc_pkg::SLOT_W-1:0]    slot,
	output logic [lhc_pkg::EVC_W-1:0]     evicted_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lhc_pkg::LIMIT_W-1:0]   cfg_data
);
	import lhc_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = IDX_W + 1;
	localparam logic [EVC_W-1:0] EVC_MAX = '1;

	state_t state_q, state_d;

	logic [LIMIT_W-1:0]  live_limit_q;
	logic [CNT_W-1:0]    live_count_q;
	logic                op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [FILL_W-1:0]   fill_q;
	logic                hit_q;
	logic                hv_q;
	logic [IDX_W-1:0]    slot_q;
	logic [IDX_W-1:0]    ref_rank_q;
	logic [EVC_W-1:0]    evc_q;

	logic                out_valid_q;
	logic                out_hit_q;
	logic                out_hv_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [EVC_W-1:0]    out_evc_q;

	cell_op_t            cell_cmd;
	logic [IDX_W-1:0]    new_rank;
	logic [CAPACITY:0]   free_chain;
	logic [CAPACITY-1:0] sel_vec;
	logic [CAPACITY-1:0] valid_vec;
	logic [CAPACITY-1:0] match_vec;
	logic [IDX_W-1:0]    rank_vec [CAPACITY];

	logic                hit_c;
	logic [IDX_W-1:0]    hit_idx_c;
	logic [IDX_W-1:0]    hit_rank_c;
	logic [IDX_W-1:0]    free_idx_c;
	logic [CNT_W-1:0]    eff_limit;
	logic                need_evict;
	logic                fill_ok;
	logic                accept;
	logic                load_out;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign out_valid     = out_valid_q;
	assign hit           = out_hit_q;
	assign handle_valid  = out_hv_q;
	assign slot          = out_slot_q;
	assign evicted_count = out_evc_q;

	assign free_chain[0] = 1'b0;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			lhc_cell #(
				.KEY_BITS (KEY_BITS),
				.RANK_W   (IDX_W)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cell_cmd),
				.key_in   (key_q),
				.ref_rank (ref_rank_q),
				.new_rank (new_rank),
				.free_in  (free_chain[g]),
				.free_out (free_chain[g+1]),
				.sel      (sel_vec[g]),
				.valid    (valid_vec[g]),
				.match    (match_vec[g]),
				.rank     (rank_vec[g])
			);
		end
	endgenerate

	always_comb begin
		hit_idx_c  = '0;
		hit_rank_c = '0;
		free_idx_c = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_idx_c  = hit_idx_c  | (match_vec[i] ? IDX_W'(i) : '0);
			hit_rank_c = hit_rank_c | (match_vec[i] ? rank_vec[i] : '0);
			free_idx_c = free_idx_c | (sel_vec[i] ? IDX_W'(i) : '0);
		end
		hit_c = |match_vec;
	end

	always_comb begin
		if (32'(live_limit_q) > 32'(CAPACITY)) begin
			eff_limit = CNT_W'(CAPACITY);
		end else if (32'(live_limit_q) < 32'(LIMIT_FLOOR)) begin
			eff_limit = CNT_W'(LIMIT_FLOOR);
		end else begin
			eff_limit = CNT_W'(live_limit_q);
		end
	end

	assign need_evict = (live_count_q >= eff_limit) && (live_count_q != '0);
	assign fill_ok    = (fill_q != FILL_DECODE_FAIL) && (fill_q != FILL_UPLOAD_FAIL);
	assign load_out   = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cell_cmd = CELL_HOLD;
		new_rank = IDX_W'(live_count_q);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				cell_cmd = CELL_CMP;
				state_d  = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (op_q == OP_PEEK) begin
					state_d = ST_DONE;
				end else if (hit_c) begin
					state_d = ST_TOUCH;
				end else if (fill_q == FILL_DECODE_FAIL) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_EVICT;
				end
			end
			ST_TOUCH: begin
				cell_cmd = CELL_TOUCH;
				new_rank = IDX_W'(live_count_q - 1'b1);
				state_d  = ST_DONE;
			end
			ST_EVICT: begin
				if (need_evict) begin
					cell_cmd = CELL_EVICT;
				end else if (fill_ok) begin
					state_d = ST_INSERT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_INSERT: begin
				if (free_chain[CAPACITY]) begin
					cell_cmd = CELL_INSERT;
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_limit_q <= LIMIT_RESET;
			live_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				live_limit_q <= cfg_data;
			end
			if (cell_cmd == CELL_EVICT) begin
				live_count_q <= live_count_q - 1'b1;
			end else if (cell_cmd == CELL_INSERT) begin
				live_count_q <= live_count_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			key_q  <= key[KEY_BITS-1:0];
			fill_q <= fill_outcome;
			hv_q   <= 1'b0;
			evc_q  <= '0;
			slot_q <= '0;
		end
		if (state_q == ST_DECIDE) begin
			hit_q      <= hit_c;
			ref_rank_q <= hit_rank_c;
			if (op_q == OP_LOOKUP && hit_c) begin
				slot_q <= hit_idx_c;
			end
		end
		if (cell_cmd == CELL_TOUCH) begin
			hv_q <= 1'b1;
		end
		if (cell_cmd == CELL_EVICT && evc_q != EVC_MAX) begin
			evc_q <= evc_q + 1'b1;
		end
		if (cell_cmd == CELL_INSERT) begin
			hv_q   <= 1'b1;
			slot_q <= free_idx_c;
		end
		if (load_out) begin
			out_hit_q  <= hit_q;
			out_hv_q   <= hv_q;
			out_slot_q <= SLOT_W'(slot_q);
			out_evc_q  <= evc_q;
		end
	end

	`LHC_ASSERT(a_match_unique, clk, arst_n, $onehot0(match_vec))
	`LHC_ASSERT(a_count_tracks_valid, clk, arst_n, $countones(valid_vec) == int'(live_count_q))
	`LHC_ASSERT(a_count_in_range, clk, arst_n, 32'(live_count_q) <= 32'(CAPACITY))
	`LHC_ASSERT_IMPL(a_evict_drops_one, clk, arst_n, cell_cmd == CELL_EVICT, live_count_q == $past(live_count_q) - 1'b1)
	`LHC_ASSERT_IMPL(a_insert_needs_miss, clk, arst_n, state_q == ST_INSERT, !hit_q && op_q == OP_LOOKUP)
endmodule
